// ===== rtl/core/video_scene_cut_detector_defines.svh =====
// ----------------------------------------------------------------------------
// Scene cut detector assertion macros
// Checks for implication and next-cycle implication on the rising clock edge.
// ----------------------------------------------------------------------------
`ifndef VIDEO_SCENE_CUT_DETECTOR_DEFINES_SVH
`define VIDEO_SCENE_CUT_DETECTOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define VSCD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define VSCD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define VSCD_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define VSCD_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/vscd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vscd_pkg
// Shared constants, widths and types of the scene cut detector.
// ----------------------------------------------------------------------------
package vscd_pkg;

    localparam int MAX_PIXELS = 2097152;
    localparam int ADDR_W     = $clog2(MAX_PIXELS);
    localparam int PC_W       = $clog2(MAX_PIXELS + 1);
    localparam int SSD_W      = PC_W + 16;
    localparam int SQ_W       = 2 * PC_W;
    localparam int VAR_W      = SQ_W + 8;
    localparam int TT_W       = 34;
    localparam int ACC_W      = 2 * VAR_W + TT_W;
    localparam int NBINS      = 256;

    localparam logic [16:0] CORR_ONE = 17'd65536;
    localparam logic [15:0] MEAN_SQ_RESET = 16'd100;
    localparam logic [16:0] CORR_RESET    = 17'd45875;
    localparam logic [31:0] CNT_MAX       = 32'hFFFF_FFFF;

    typedef enum logic {
        REG_MEAN_SQ  = 1'b0,
        REG_CORR_THR = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] frame_index;
        logic [31:0] scene_id;
        logic        scene_changed;
    } result_t;

endpackage

// ===== rtl/core/vscd_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vscd_mul
// Shared 32x32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module vscd_mul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);
    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= 64'(a) * 64'(b);
    end

    assign p = p_reg;
endmodule

// ===== rtl/core/vscd_frame_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vscd_frame_mem
// Previous-frame pixel store, one write and one registered read port.
// ----------------------------------------------------------------------------
module vscd_frame_mem (
    input  logic                      clk,
    input  logic                      we,
    input  logic [vscd_pkg::ADDR_W-1:0] waddr,
    input  logic [7:0]                wdata,
    input  logic                      re,
    input  logic [vscd_pkg::ADDR_W-1:0] raddr,
    output logic [7:0]                rdata
);
    import vscd_pkg::*;

    logic [7:0] mem [MAX_PIXELS];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/core/vscd_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vscd_seq
// Sequencer: pixel accumulation, histogram walk and exact correlation test,
// all multiplications through the shared multiplier.
// ----------------------------------------------------------------------------
module vscd_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pixel_valid,
    output logic              pixel_ready,
    input  logic [7:0]        pixel,
    input  logic              end_of_frame,
    input  logic [15:0]       mean_sq_threshold,
    input  logic [16:0]       corr_threshold,
    output logic [31:0]       mul_a,
    output logic [31:0]       mul_b,
    input  logic [63:0]       mul_p,
    output logic              res_valid,
    input  logic              res_ready,
    output vscd_pkg::result_t res
);
    import vscd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_PIX_RD, S_PIX_ACC, S_W_RD, S_W_AA, S_W_BB, S_W_AB, S_W_ACC,
        S_THR, S_THR_CHK, S_C_LOAD, S_C_ISS, S_C_ACC, S_C_STORE, S_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_SAA, OP_SBB, OP_SAB, OP_COV, OP_TT, OP_VV, OP_RHS
    } op_t;

    state_t               state_reg;
    op_t                  op_reg;
    logic [7:0]           px_reg;
    logic                 eof_reg;
    logic [PC_W-1:0]      pc_reg;
    logic [PC_W-1:0]      prev_total_reg;
    logic [SSD_W-1:0]     ssd_reg;
    logic [31:0]          frame_cnt_reg;
    logic [31:0]          scene_cnt_reg;
    logic                 have_prev_reg;
    logic                 cut_reg;
    logic [7:0]           bin_reg;
    logic [PC_W-1:0]      a_reg;
    logic [PC_W-1:0]      b_reg;
    logic [PC_W-1:0]      sa_reg;
    logic [PC_W-1:0]      sb_reg;
    logic [SQ_W-1:0]      saa_reg;
    logic [SQ_W-1:0]      sbb_reg;
    logic [SQ_W-1:0]      sab_reg;
    logic [VAR_W-1:0]     va_reg;
    logic [VAR_W-1:0]     vb_reg;
    logic [VAR_W-1:0]     cov_reg;
    logic [2*VAR_W-1:0]   vv_reg;
    logic [TT_W-1:0]      tt_reg;
    logic [ACC_W-1:0]     lhs_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [127:0]         big_a_reg;
    logic [63:0]          big_b_reg;
    logic [1:0]           li_reg;
    logic                 lj_reg;
    logic [1:0]           a_last_reg;
    logic                 b_last_reg;

    // histogram stores
    logic [PC_W-1:0] cur_mem  [NBINS];
    logic [PC_W-1:0] prev_mem [NBINS];
    logic [NBINS-1:0] cur_valid_reg;
    logic [PC_W-1:0] cur_rdata_reg;
    logic            cur_rvalid_reg;
    logic [PC_W-1:0] prev_rdata_reg;

    logic             accept;
    logic             store;
    logic             fr_re;
    logic [7:0]       fr_rdata;
    logic [7:0]       diff;
    logic [7:0]       hist_raddr;
    logic             hist_re;
    logic [PC_W-1:0]  cur_val;
    logic [2:0]       limb_k;
    logic [ACC_W-1:0] acc_sum;
    logic [VAR_W-1:0] pos;
    logic [VAR_W-1:0] neg;
    logic [63:0]      thr_prod;
    logic [31:0]      scene_next;

    assign pixel_ready = (state_reg == S_IDLE);
    assign accept      = pixel_valid && pixel_ready;
    assign store       = pc_reg < PC_W'(MAX_PIXELS);
    assign fr_re       = accept && store;
    assign cur_val     = cur_rvalid_reg ? cur_rdata_reg : '0;

    // only positions the previous frame wrote are compared
    always_comb
    begin
        diff = 8'd0;
        if (have_prev_reg && (pc_reg < prev_total_reg) && (px_reg > fr_rdata))
        begin
            diff = px_reg - fr_rdata;
        end
    end

    vscd_frame_mem u_frame_mem (
        .clk   (clk),
        .we    (state_reg == S_PIX_RD),
        .waddr (pc_reg[ADDR_W-1:0]),
        .wdata (px_reg),
        .re    (fr_re),
        .raddr (pc_reg[ADDR_W-1:0]),
        .rdata (fr_rdata)
    );

    assign hist_re    = fr_re || (state_reg == S_W_RD);
    assign hist_raddr = (state_reg == S_IDLE) ? pixel : bin_reg;

    always_ff @(posedge clk)
    begin
        if (hist_re)
        begin
            cur_rdata_reg  <= cur_mem[hist_raddr];
            prev_rdata_reg <= prev_mem[hist_raddr];
        end
        if (state_reg == S_PIX_RD)
        begin
            cur_mem[px_reg] <= cur_val + PC_W'(1);
        end
        if (state_reg == S_W_AA)
        begin
            prev_mem[bin_reg] <= cur_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg  <= '0;
            cur_rvalid_reg <= 1'b0;
        end
        else
        begin
            if (hist_re)
            begin
                cur_rvalid_reg <= cur_valid_reg[hist_raddr];
            end
            if (state_reg == S_PIX_RD)
            begin
                cur_valid_reg[px_reg] <= 1'b1;
            end
            else if (state_reg == S_W_ACC && bin_reg == 8'(NBINS - 1))
            begin
                cur_valid_reg <= '0;
            end
        end
    end

    assign limb_k  = {1'b0, li_reg} + {2'b0, lj_reg};
    assign acc_sum = acc_reg + (ACC_W'(mul_p) << {limb_k, 5'd0});
    assign pos     = {sab_reg, 8'd0};
    assign neg     = acc_reg[VAR_W-1:0];
    assign thr_prod = mul_p;

    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (state_reg)
            S_PIX_RD:
            begin
                mul_a = 32'(diff);
                mul_b = 32'(diff);
            end
            S_W_AA:
            begin
                mul_a = 32'(cur_val);
                mul_b = 32'(cur_val);
            end
            S_W_BB:
            begin
                mul_a = 32'(b_reg);
                mul_b = 32'(b_reg);
            end
            S_W_AB:
            begin
                mul_a = 32'(a_reg);
                mul_b = 32'(b_reg);
            end
            S_THR:
            begin
                mul_a = 32'(mean_sq_threshold);
                mul_b = 32'(pc_reg);
            end
            S_C_ISS:
            begin
                mul_a = big_a_reg[li_reg * 32 +: 32];
                mul_b = big_b_reg[lj_reg * 32 +: 32];
            end
            default:
            begin
                mul_a = 32'd0;
            end
        endcase
    end

    assign scene_next = (cut_reg && scene_cnt_reg != CNT_MAX) ?
                        scene_cnt_reg + 32'd1 : scene_cnt_reg;
    assign res_valid  = (state_reg == S_DONE);
    assign res.frame_index   = frame_cnt_reg;
    assign res.scene_id      = scene_next;
    assign res.scene_changed = cut_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_SAA;
            pc_reg         <= '0;
            prev_total_reg <= '0;
            ssd_reg        <= '0;
            frame_cnt_reg  <= '0;
            scene_cnt_reg  <= 32'd1;
            have_prev_reg  <= 1'b0;
            cut_reg        <= 1'b0;
            bin_reg        <= '0;
            sa_reg         <= '0;
            sb_reg         <= '0;
            saa_reg        <= '0;
            sbb_reg        <= '0;
            sab_reg        <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        px_reg  <= pixel;
                        eof_reg <= end_of_frame;
                        if (store)
                        begin
                            state_reg <= S_PIX_RD;
                        end
                        else if (end_of_frame)
                        begin
                            state_reg <= S_W_RD;
                        end
                    end
                end
                S_PIX_RD:
                begin
                    pc_reg    <= pc_reg + PC_W'(1);
                    state_reg <= S_PIX_ACC;
                end
                S_PIX_ACC:
                begin
                    ssd_reg   <= ssd_reg + SSD_W'(mul_p[15:0]);
                    state_reg <= eof_reg ? S_W_RD : S_IDLE;
                end
                S_W_RD:
                begin
                    state_reg <= S_W_AA;
                end
                S_W_AA:
                begin
                    a_reg     <= cur_val;
                    b_reg     <= prev_rdata_reg;
                    sa_reg    <= sa_reg + cur_val;
                    sb_reg    <= sb_reg + prev_rdata_reg;
                    state_reg <= S_W_BB;
                end
                S_W_BB:
                begin
                    saa_reg   <= saa_reg + SQ_W'(mul_p);
                    state_reg <= S_W_AB;
                end
                S_W_AB:
                begin
                    sbb_reg   <= sbb_reg + SQ_W'(mul_p);
                    state_reg <= S_W_ACC;
                end
                S_W_ACC:
                begin
                    sab_reg   <= sab_reg + SQ_W'(mul_p);
                    bin_reg   <= bin_reg + 8'd1;
                    state_reg <= (bin_reg == 8'(NBINS - 1)) ? S_THR : S_W_RD;
                end
                S_THR:
                begin
                    state_reg <= S_THR_CHK;
                end
                S_THR_CHK:
                begin
                    if (have_prev_reg && pc_reg == prev_total_reg &&
                        64'(ssd_reg) > thr_prod)
                    begin
                        op_reg    <= OP_SAA;
                        state_reg <= S_C_LOAD;
                    end
                    else
                    begin
                        cut_reg   <= 1'b0;
                        state_reg <= S_DONE;
                    end
                end
                S_C_LOAD:
                begin
                    acc_reg    <= '0;
                    li_reg     <= 2'd0;
                    lj_reg     <= 1'b0;
                    a_last_reg <= 2'd0;
                    b_last_reg <= 1'b0;
                    case (op_reg)
                        OP_SAA:
                        begin
                            big_a_reg <= 128'(sa_reg);
                            big_b_reg <= 64'(sa_reg);
                        end
                        OP_SBB:
                        begin
                            big_a_reg <= 128'(sb_reg);
                            big_b_reg <= 64'(sb_reg);
                        end
                        OP_SAB:
                        begin
                            big_a_reg <= 128'(sa_reg);
                            big_b_reg <= 64'(sb_reg);
                        end
                        OP_COV:
                        begin
                            big_a_reg  <= 128'(cov_reg);
                            big_b_reg  <= 64'(cov_reg);
                            a_last_reg <= 2'd1;
                            b_last_reg <= 1'b1;
                        end
                        OP_TT:
                        begin
                            big_a_reg <= 128'(corr_threshold);
                            big_b_reg <= 64'(corr_threshold);
                        end
                        OP_VV:
                        begin
                            big_a_reg  <= 128'(va_reg);
                            big_b_reg  <= 64'(vb_reg);
                            a_last_reg <= 2'd1;
                            b_last_reg <= 1'b1;
                        end
                        default:
                        begin
                            big_a_reg  <= 128'(vv_reg);
                            big_b_reg  <= 64'(tt_reg);
                            a_last_reg <= 2'd3;
                            b_last_reg <= 1'b1;
                        end
                    endcase
                    state_reg <= S_C_ISS;
                end
                S_C_ISS:
                begin
                    state_reg <= S_C_ACC;
                end
                S_C_ACC:
                begin
                    acc_reg <= acc_sum;
                    if (lj_reg == b_last_reg)
                    begin
                        lj_reg <= 1'b0;
                        if (li_reg == a_last_reg)
                        begin
                            state_reg <= S_C_STORE;
                        end
                        else
                        begin
                            li_reg    <= li_reg + 2'd1;
                            state_reg <= S_C_ISS;
                        end
                    end
                    else
                    begin
                        lj_reg    <= 1'b1;
                        state_reg <= S_C_ISS;
                    end
                end
                S_C_STORE:
                begin
                    state_reg <= S_C_LOAD;
                    case (op_reg)
                        OP_SAA:
                        begin
                            va_reg <= {saa_reg, 8'd0} - acc_reg[VAR_W-1:0];
                            op_reg <= OP_SBB;
                        end
                        OP_SBB:
                        begin
                            vb_reg <= {sbb_reg, 8'd0} - acc_reg[VAR_W-1:0];
                            op_reg <= OP_SAB;
                        end
                        OP_SAB:
                        begin
                            // flat histogram: correlation is exactly one
                            if (va_reg == '0 || vb_reg == '0)
                            begin
                                cut_reg   <= corr_threshold > CORR_ONE;
                                state_reg <= S_DONE;
                            end
                            else if (pos < neg)
                            begin
                                cut_reg   <= 1'b1;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                cov_reg <= pos - neg;
                                op_reg  <= OP_COV;
                            end
                        end
                        OP_COV:
                        begin
                            lhs_reg <= {acc_reg[ACC_W-33:0], 32'd0};
                            op_reg  <= OP_TT;
                        end
                        OP_TT:
                        begin
                            tt_reg <= acc_reg[TT_W-1:0];
                            op_reg <= OP_VV;
                        end
                        OP_VV:
                        begin
                            vv_reg <= acc_reg[2*VAR_W-1:0];
                            op_reg <= OP_RHS;
                        end
                        default:
                        begin
                            cut_reg   <= lhs_reg < acc_reg;
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        scene_cnt_reg  <= scene_next;
                        if (frame_cnt_reg != CNT_MAX)
                        begin
                            frame_cnt_reg <= frame_cnt_reg + 32'd1;
                        end
                        prev_total_reg <= pc_reg;
                        pc_reg         <= '0;
                        ssd_reg        <= '0;
                        have_prev_reg  <= 1'b1;
                        bin_reg        <= '0;
                        sa_reg         <= '0;
                        sb_reg         <= '0;
                        saa_reg        <= '0;
                        sbb_reg        <= '0;
                        sab_reg        <= '0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== rtl/core/video_scene_cut_detector.sv =====
`timescale 1ns / 1ps
// A stored pixel passes S_IDLE, S_PIX_RD and S_PIX_ACC; a pixel past the frame
// limit is taken in S_IDLE alone. End of frame adds a walk over all 256 bins
// (S_W_RD to S_W_ACC each), a threshold check and the correlation on the multiplier.
// One item at a time; a finished result waits in the output register.
// Reset is asynchronous; histogram valid bits clear at once, no clearing pass.
// ----------------------------------------------------------------------------
// video_scene_cut_detector
// Scene cut detection from pixel differences and histogram correlation.
// ----------------------------------------------------------------------------
module video_scene_cut_detector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        pixel_valid,
    output logic        pixel_ready,
    input  logic [7:0]  pixel,
    input  logic        end_of_frame,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [31:0] frame_index,
    output logic [31:0] scene_id,
    output logic        scene_changed
);
    import vscd_pkg::*;

    `include "video_scene_cut_detector_defines.svh"

    logic [15:0] mean_sq_reg;
    logic [16:0] corr_thr_reg;
    logic        out_valid_reg;
    result_t     out_res_reg;
    logic        cfg_write;
    reg_idx_t    cfg_idx;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic        res_valid;
    logic        res_ready;
    result_t     res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[2]);

    always_comb
    begin
        case (cfg_idx)
            REG_MEAN_SQ:  prdata = 32'(mean_sq_reg);
            REG_CORR_THR: prdata = 32'(corr_thr_reg);
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_sq_reg  <= MEAN_SQ_RESET;
            corr_thr_reg <= CORR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_MEAN_SQ:  mean_sq_reg  <= pwdata[15:0];
                REG_CORR_THR: corr_thr_reg <= pwdata[16:0];
                default:      mean_sq_reg  <= mean_sq_reg;
            endcase
        end
    end

    vscd_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    vscd_seq u_seq (
        .clk               (clk),
        .rst_n             (rst_n),
        .pixel_valid       (pixel_valid),
        .pixel_ready       (pixel_ready),
        .pixel             (pixel),
        .end_of_frame      (end_of_frame),
        .mean_sq_threshold (mean_sq_reg),
        .corr_threshold    (corr_thr_reg),
        .mul_a             (mul_a),
        .mul_b             (mul_b),
        .mul_p             (mul_p),
        .res_valid         (res_valid),
        .res_ready         (res_ready),
        .res               (res)
    );

    assign res_ready = !out_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign result_valid  = out_valid_reg;
    assign frame_index   = out_res_reg.frame_index;
    assign scene_id      = out_res_reg.scene_id;
    assign scene_changed = out_res_reg.scene_changed;

    // a cut always moves past the first scene, and never on the first frame
    `VSCD_ASSERT_IMP(a_cut_scene, clk, rst_n, result_valid && scene_changed, scene_id != 32'd1)
    `VSCD_ASSERT_IMP(a_cut_frame, clk, rst_n, result_valid && scene_changed, frame_index != 32'd0)
    `VSCD_ASSERT_NXT(a_cfg_wr, clk, rst_n, cfg_write && cfg_idx == REG_MEAN_SQ, mean_sq_reg == $past(pwdata[15:0]))
endmodule

// ===== test/video_scene_cut_detector_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_scene_cut_detector_checker
// Watches the register port and both item channels, predicts the per-frame
// scene result and compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module video_scene_cut_detector_checker
    import vscd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        pixel_valid,
    input  logic        pixel_ready,
    input  logic [7:0]  pixel,
    input  logic        end_of_frame,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [31:0] frame_index,
    input  logic [31:0] scene_id,
    input  logic        scene_changed,
    output int          failures,
    output int          pending
);

    logic [15:0]  mean_sq_thr;
    logic [16:0]  corr_thr;
    logic [7:0]   prev_pixels [MAX_PIXELS];
    int unsigned  cur_hist [NBINS];
    int unsigned  last_hist [NBINS];
    logic [63:0]  sq_sum;
    int unsigned  pix_cnt;
    int unsigned  last_total;
    logic [31:0]  frame_cnt;
    logic [31:0]  scene_cnt;
    bit           have_last;
    result_t      scene_results [$];

    // exact integer test of histogram correlation < t / 2^16
    function automatic bit hist_corr_below(input logic [16:0] t);
        logic [63:0]  sa, sb, saa, sbb, sab, va, vb, pos, neg, cov;
        logic [191:0] lhs, rhs;
        sa = 0; sb = 0; saa = 0; sbb = 0; sab = 0;
        for (int i = 0; i < NBINS; i++)
        begin
            sa  += cur_hist[i];
            sb  += last_hist[i];
            saa += 64'(cur_hist[i]) * cur_hist[i];
            sbb += 64'(last_hist[i]) * last_hist[i];
            sab += 64'(cur_hist[i]) * last_hist[i];
        end
        va = 64'd256 * saa - sa * sa;
        vb = 64'd256 * sbb - sb * sb;
        if (va == 0 || vb == 0)
            return t > CORR_ONE;
        pos = 64'd256 * sab;
        neg = sa * sb;
        if (pos < neg)
            return 1'b1;
        cov = pos - neg;
        lhs = (192'(cov) * 192'(cov)) << 32;
        rhs = 192'(va) * 192'(vb) * 192'(t) * 192'(t);
        return lhs < rhs;
    endfunction

    function automatic void take_pixel(input logic [7:0] px, input logic eof);
        logic [7:0] pv;
        bit         cut;
        result_t    r;
        if (pix_cnt < MAX_PIXELS)
        begin
            if (have_last && pix_cnt < last_total)
            begin
                pv = prev_pixels[pix_cnt];
                if (px > pv)
                    sq_sum += 64'(px - pv) * 64'(px - pv);
            end
            prev_pixels[pix_cnt] = px;
            cur_hist[px]++;
            pix_cnt++;
        end
        if (!eof)
            return;
        cut = 1'b0;
        if (have_last && pix_cnt == last_total)
            cut = (sq_sum > 64'(mean_sq_thr) * pix_cnt) && hist_corr_below(corr_thr);
        if (cut && scene_cnt != CNT_MAX)
            scene_cnt++;
        r.frame_index   = frame_cnt;
        r.scene_id      = scene_cnt;
        r.scene_changed = cut;
        scene_results.push_back(r);
        if (frame_cnt != CNT_MAX)
            frame_cnt++;
        for (int i = 0; i < NBINS; i++)
        begin
            last_hist[i] = cur_hist[i];
            cur_hist[i]  = 0;
        end
        last_total = pix_cnt;
        pix_cnt    = 0;
        sq_sum     = 0;
        have_last  = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
        begin
            mean_sq_thr = MEAN_SQ_RESET;
            corr_thr    = CORR_RESET;
            for (int i = 0; i < NBINS; i++)
                cur_hist[i] = 0;
            sq_sum     = 0;
            pix_cnt    = 0;
            last_total = 0;
            frame_cnt  = 0;
            scene_cnt  = 1;
            have_last  = 1'b0;
            scene_results.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[2]))
                    REG_MEAN_SQ:  mean_sq_thr = pwdata[15:0];
                    REG_CORR_THR: corr_thr    = pwdata[16:0];
                    default:      ;
                endcase
            end
            if (result_valid && result_ready)
            begin
                if (scene_results.size() == 0)
                begin
                    $error("unexpected result: frame_index %0d", frame_index);
                    failures++;
                end
                else
                begin
                    e = scene_results.pop_front();
                    if (frame_index !== e.frame_index)
                    begin
                        $error("frame_index: expected %0d, actual %0d", e.frame_index,
                               frame_index);
                        failures++;
                    end
                    if (scene_id !== e.scene_id)
                    begin
                        $error("scene_id: expected %0d, actual %0d", e.scene_id, scene_id);
                        failures++;
                    end
                    if (scene_changed !== e.scene_changed)
                    begin
                        $error("scene_changed: expected %0b, actual %0b", e.scene_changed,
                               scene_changed);
                        failures++;
                    end
                end
            end
            if (pixel_valid && pixel_ready)
                take_pixel(pixel, end_of_frame);
        end
        pending = scene_results.size();
    end

    initial
    begin
        failures = 0;
        pending  = 0;
    end

endmodule

// ===== test/video_scene_cut_detector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_scene_cut_detector_tb
// Drives frames of grey pixels and register settings into the scene cut
// detector; the checker predicts and compares each per-frame result.
// ----------------------------------------------------------------------------
module video_scene_cut_detector_tb;
    import vscd_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        pixel_valid = 1'b0;
    logic        pixel_ready;
    logic [7:0]  pixel = '0;
    logic        end_of_frame = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [31:0] frame_index;
    logic [31:0] scene_id;
    logic        scene_changed;
    int          failures;
    int          pending;

    bit          no_idle = 1'b0;
    bit          long_hold_req = 1'b0;
    logic [7:0]  last_img [$];
    int          pixels_sent = 0;

    always #4 clk = ~clk;

    video_scene_cut_detector i_dut (.*);

    video_scene_cut_detector_checker i_checker (.*);

    initial
    begin
        #100ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stall bursts, one long hold-off on request
    initial
    begin
        bit held;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req && !held)
            begin
                held = 1'b1;
                result_ready = 1'b0;
                repeat (4000) @(negedge clk);
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                result_ready = 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge clk);
            end
            else
                result_ready = 1'b1;
        end
    end

    task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = 3'(int'(idx) * 4);
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_pixel(input logic [7:0] px, input logic eof);
        @(negedge clk);
        if (!no_idle && $urandom_range(0, 4) == 0)
        begin
            pixel_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        pixel_valid  = 1'b1;
        pixel        = px;
        end_of_frame = eof;
        do
            @(posedge clk);
        while (!pixel_ready);
        pixels_sent++;
    endtask

    // wait until every expected result is back, then let the block settle
    task automatic drain();
        @(negedge clk);
        pixel_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // kind: 0 random, 1 previous with small noise, 2 inverted previous,
    // 3 constant, 4 only black and white
    task automatic send_frame(input int len, input int kind, input logic [7:0] level);
        logic [7:0] img [$];
        logic [7:0] px;
        int         n;
        for (int i = 0; i < len; i++)
        begin
            n = $urandom_range(0, 6) - 3;
            case (kind)
                1:       px = (i < last_img.size()) ? 8'(int'(last_img[i]) + n) : 8'($urandom);
                2:       px = (i < last_img.size()) ? ~last_img[i] : 8'($urandom);
                3:       px = level;
                4:       px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default: px = 8'($urandom);
            endcase
            img.push_back(px);
            send_pixel(px, i == len - 1);
        end
        last_img = img;
    endtask

    initial
    begin
        int len;
        int kind;
        logic [15:0] mean_cfg [7];
        logic [16:0] corr_cfg [7];
        mean_cfg = '{16'd100, 16'd0, 16'd65025, 16'd3, 16'd40, 16'd0, 16'd1};
        corr_cfg = '{17'd45875, 17'd65536, 17'd0, 17'd60000, 17'd65536,
                     17'd30000, 17'd65535};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: first frame, black to white, size change, flat frames
        send_frame(1, 3, 8'h00);
        send_frame(1, 3, 8'hFF);
        send_frame(2, 3, 8'h00);
        send_frame(2, 3, 8'hFF);
        send_frame(3, 4, 8'h00);
        send_frame(3, 2, 8'h00);
        send_frame(3, 1, 8'h00);
        drain();
        reg_write(REG_MEAN_SQ, 32'd0);
        reg_write(REG_CORR_THR, 32'd65536);
        send_frame(4, 3, 8'h80);
        send_frame(4, 3, 8'h81);
        send_frame(4, 0, 8'h00);
        send_frame(4, 1, 8'h00);
        drain();

        for (int ph = 0; ph < 7; ph++)
        begin
            reg_write(REG_MEAN_SQ, 32'(mean_cfg[ph]));
            reg_write(REG_CORR_THR, 32'(corr_cfg[ph]));
            if (ph == 1)
                long_hold_req = 1'b1;
            if (ph == 6)
                no_idle = 1'b1;
            for (int k = 0; k < 180; k += len)
            begin
                len  = ($urandom_range(0, 9) < 7 && last_img.size() > 0) ?
                       last_img.size() : $urandom_range(1, 24);
                kind = $urandom_range(0, 9);
                kind = (kind < 3) ? 0 : (kind < 6) ? 1 : (kind < 8) ? 2 : kind - 5;
                send_frame(len, kind, 8'($urandom));
            end
            drain();
        end

        if (failures == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
